/* rtl/brmc_pkg.sv */
// ----------------------------------------------------------------------------
// brmc_pkg: shared types and constants for the button and remote mode
// controller.
// Holds the transfer payload structs, the configuration bundle, field codes
// and the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package brmc_pkg;

  // Controller modes
  typedef enum logic [1:0] {
    MODE_RUN    = 2'd0,
    MODE_LEARN  = 2'd1,
    MODE_DELETE = 2'd2
  } mode_e;

  // Pending motor actions
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_UP   = 3'd1;
  localparam logic [2:0] ACT_DOWN = 3'd2;
  localparam logic [2:0] ACT_STOP = 3'd3;
  localparam logic [2:0] ACT_LOCK = 3'd4;

  // Button event codes
  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_SHORT  = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;
  localparam logic [1:0] BTN_LONG   = 2'd3;

  // Remote event codes that matter here
  localparam logic [3:0] REM_BUTTON_A    = 4'd1;
  localparam logic [3:0] REM_BUTTON_D    = 4'd4;
  localparam logic [3:0] REM_INVALIDATED = 4'd8;
  localparam logic [3:0] REM_FULL        = 4'd9;
  localparam logic [3:0] REM_FLASH_ERROR = 4'd11;
  localparam logic [3:0] REM_STORED      = 4'd12;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_DONE_HOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELETE_HOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_BLINK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_BLINK      = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_LEARN_DONE_HOLD = 16'd3000;
  localparam logic [15:0] RST_LEARN_TIMEOUT   = 16'd5000;
  localparam logic [15:0] RST_DELETE_HOLD     = 16'd3000;
  localparam logic [15:0] RST_FAST_BLINK      = 16'd100;
  localparam logic [15:0] RST_SLOW_BLINK      = 16'd500;

  typedef struct packed {
    logic [15:0] learn_done_hold_ms;
    logic [15:0] learn_timeout_ms;
    logic [15:0] delete_hold_ms;
    logic [15:0] fast_blink_ms;
    logic [15:0] slow_blink_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  button1_event;
    logic [1:0]  button2_event;
    logic [3:0]  remote_code;
  } in_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        motor_request_valid;
    logic [1:0]  motor_command;
    logic [15:0] led_blink_ms;
    logic        notify_valid;
    logic        notify_policy;
    logic        erase_all;
  } out_t;

endpackage

`default_nettype wire

/* rtl/brmc_cfg.sv */
// ----------------------------------------------------------------------------
// brmc_cfg: configuration register file
// Five 16-bit timing and blink registers, written over the config channel.
// Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module brmc_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [brmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i,
  output brmc_pkg::cfg_t                      cfg_o
);
  import brmc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always able to take a write
  assign cfg_ready_o = 1'b1;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LEARN_DONE_HOLD: cfg_d.learn_done_hold_ms = cfg_data_i;
        CFG_LEARN_TIMEOUT:   cfg_d.learn_timeout_ms   = cfg_data_i;
        CFG_DELETE_HOLD:     cfg_d.delete_hold_ms     = cfg_data_i;
        CFG_FAST_BLINK:      cfg_d.fast_blink_ms      = cfg_data_i;
        CFG_SLOW_BLINK:      cfg_d.slow_blink_ms      = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_done_hold_ms <= RST_LEARN_DONE_HOLD;
      cfg_q.learn_timeout_ms   <= RST_LEARN_TIMEOUT;
      cfg_q.delete_hold_ms     <= RST_DELETE_HOLD;
      cfg_q.fast_blink_ms      <= RST_FAST_BLINK;
      cfg_q.slow_blink_ms      <= RST_SLOW_BLINK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/brmc_step.sv */
// ----------------------------------------------------------------------------
// brmc_step: per-tick mode logic and controller state
// Evaluates one tick against the held state and commits the new state when
// the tick is advanced into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brmc_step (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire brmc_pkg::cfg_t cfg_i,
  input  wire brmc_pkg::in_t  tick_i,
  output brmc_pkg::out_t      res_o
);
  import brmc_pkg::*;

  mode_e       mode_q, mode_d;
  logic [2:0]  pend_q, pend_d;
  logic [31:0] entry_q, entry_d;
  logic        done_q, done_d;

  logic [31:0] elapsed;

  assign elapsed = tick_i.now_ms - entry_q;

  // Next state and result for this tick
  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    entry_d = entry_q;
    done_d  = done_q;
    res_o   = '0;

    // button pairs and single presses
    if (mode_q == MODE_RUN) begin
      if (tick_i.button1_event == BTN_LONG && tick_i.button2_event == BTN_LONG) begin
        mode_d = MODE_DELETE;
      end else if (tick_i.button1_event == BTN_MIDDLE &&
                   tick_i.button2_event == BTN_MIDDLE) begin
        mode_d = MODE_LEARN;
      end else if (tick_i.button1_event == BTN_SHORT &&
                   tick_i.button2_event == BTN_NONE) begin
        pend_d = ACT_UP;
      end else if (tick_i.button1_event == BTN_NONE &&
                   tick_i.button2_event == BTN_SHORT) begin
        pend_d = ACT_DOWN;
      end
    end

    // remote events; buttons A to D map directly onto actions
    if (mode_q == MODE_RUN) begin
      if (tick_i.remote_code >= REM_BUTTON_A && tick_i.remote_code <= REM_BUTTON_D) begin
        pend_d = tick_i.remote_code[2:0];
      end
    end else if (mode_q == MODE_LEARN) begin
      if (tick_i.remote_code == REM_INVALIDATED ||
          tick_i.remote_code == REM_FLASH_ERROR) begin
        mode_d = MODE_RUN;
      end else if (tick_i.remote_code == REM_FULL ||
                   tick_i.remote_code == REM_STORED) begin
        done_d = 1'b1;
      end
    end

    // time limits, strictly greater than the programmed hold
    if (mode_q == MODE_LEARN) begin
      if (done_d) begin
        if (elapsed > {16'd0, cfg_i.learn_done_hold_ms}) begin
          done_d = 1'b0;
          mode_d = MODE_RUN;
        end
      end else if (elapsed > {16'd0, cfg_i.learn_timeout_ms}) begin
        mode_d = MODE_RUN;
      end
    end else if (mode_q == MODE_DELETE) begin
      if (elapsed > {16'd0, cfg_i.delete_hold_ms}) begin
        res_o.erase_all = 1'b1;
        mode_d          = MODE_RUN;
      end
    end

    // mode change
    if (mode_d != mode_q) begin
      entry_d = tick_i.now_ms;
      if (mode_d == MODE_LEARN) begin
        res_o.notify_valid  = 1'b1;
        res_o.notify_policy = 1'b1;
      end else if (mode_d == MODE_RUN) begin
        res_o.notify_valid  = 1'b1;
      end
    end

    // action in the mode the tick ends in
    case (mode_d)
      MODE_RUN: begin
        if (pend_d >= ACT_UP && pend_d <= ACT_LOCK) begin
          res_o.motor_request_valid = 1'b1;
          res_o.motor_command       = 2'(pend_d - ACT_UP);
        end
        pend_d = ACT_NONE;
      end
      MODE_LEARN: begin
        res_o.led_blink_ms = done_d ? cfg_i.fast_blink_ms : cfg_i.slow_blink_ms;
      end
      default: begin
        res_o.led_blink_ms = cfg_i.fast_blink_ms;
      end
    endcase

    res_o.mode = mode_d;
  end

  // State commits only with the tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RUN;
      pend_q  <= ACT_NONE;
      entry_q <= '0;
      done_q  <= 1'b0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      entry_q <= entry_d;
      done_q  <= done_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/button_remote_mode_controller_top.sv */
// ----------------------------------------------------------------------------
// button_remote_mode_controller_top: button and remote mode controller
// Each input transfer is one controller tick: time, two button events and a
// remote event. Each tick yields exactly one result transfer with the mode,
// motor request, LED period, receiver policy notice and erase-all request.
//
// Channels: in (in_valid_i/in_ready_o/in_data_i), out (out_valid_o/
// out_ready_i/out_data_o), config (cfg_valid_i/cfg_ready_o/cfg_index_i/
// cfg_data_i). Config is always ready; write it only while no tick is in
// flight.
// Path: a tick is registered in the input register at its input transfer and
// is evaluated into the result register when it advances; the result is
// offered from the result register.
// Throughput: one tick per cycle while out_ready_i is high; the single state
// update per tick is one 32-bit subtract and compare deep.
// Reset: mode normal, nothing pending, entry time zero, learn flag clear,
// registers at their defaults, both pipeline registers empty.
// Stall: while out_ready_i is low the result holds; one more tick is taken
// into the input register, then in_ready_o drops until the result moves.
// ----------------------------------------------------------------------------
`default_nettype none

module button_remote_mode_controller_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire brmc_pkg::in_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output brmc_pkg::out_t                      out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [brmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i
);
  import brmc_pkg::*;

  cfg_t cfg;
  in_t  in_q;
  logic in_valid_q;
  out_t res, out_q;
  logic out_valid_q;
  logic adv;

  // Advance a held tick when the result register is free or draining
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  brmc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  brmc_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg),
    .tick_i (in_q),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Assertions
  a_erase_returns_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.erase_all |->
      out_q.mode == MODE_RUN && out_q.notify_valid && !out_q.notify_policy)
    else $error("erase-all without return to normal mode");

  a_motor_only_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.motor_request_valid |-> out_q.mode == MODE_RUN)
    else $error("motor request outside normal mode");

  a_led_off_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.mode == MODE_RUN |-> out_q.led_blink_ms == 16'd0)
    else $error("LED period set in normal mode");

  a_tick_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_q))
    else $error("held tick lost while result stalled");

  a_stall_no_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !adv)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
